/* src/cbdp_pkg.sv */
package cbdp_pkg;

   // Block geometry
   localparam int BUFFER_LENGTH    = 1024;
   localparam int SLOTS_PER_PERIOD = 20;
   localparam int POWER_MODULO     = 2;
   localparam int MAX_KEY_BITS     = 64;

   // Derived widths
   localparam int SLOT_W       = $clog2(BUFFER_LENGTH);
   localparam int OFF_W        = $clog2(SLOTS_PER_PERIOD);
   localparam int PERIOD_W     = $clog2(BUFFER_LENGTH / SLOTS_PER_PERIOD + 1);
   localparam int PHASE_W      = $clog2(POWER_MODULO);
   localparam int HALF_PERIOD  = SLOTS_PER_PERIOD / 2;
   localparam int KEY_LEN_W    = 7;
   localparam int KEY_IDX_W    = 6;
   localparam int SPAN_W       = $clog2(MAX_KEY_BITS * SLOTS_PER_PERIOD + 1);
   localparam int CMP_W        = (SPAN_W > SLOT_W + 1) ? SPAN_W : SLOT_W + 1;
   localparam int WORD_W       = 16;
   localparam int SLOT_INDEX_W = 10;

   // Register file
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_LSB    = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_BITS       = 3'd0,
      REG_KEY_LENGTH     = 3'd1,
      REG_HIGH_MASK      = 3'd2,
      REG_LOW_MASK       = 3'd3,
      REG_CLAMP_MASK     = 3'd4,
      REG_OWN_CLAMP_MASK = 3'd5
   } reg_index_type;

   localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = KEY_LEN_W'(1);

   typedef struct packed {
      logic [63:0]          key_bits;
      logic [KEY_LEN_W-1:0] key_length;
      logic [WORD_W-1:0]    high_mask;
      logic [WORD_W-1:0]    low_mask;
      logic [WORD_W-1:0]    clamp_mask;
      logic [WORD_W-1:0]    own_clamp_mask;
   } cfg_type;

   // Register defaults: key length 1, everything else clear
   localparam cfg_type CFG_RESET = cfg_type'({64'd0, KEY_LENGTH_RESET, {4*WORD_W{1'b0}}});

   typedef struct packed {
      logic [WORD_W-1:0]       port_word;
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic                    last;
      logic                    key_too_long;
   } rsp_payload_type;

endpackage

/* src/cbdp_req_if.sv */
interface cbdp_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

/* src/cbdp_rsp_if.sv */
interface cbdp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [cbdp_pkg::WORD_W-1:0]           port_word;
   logic [cbdp_pkg::SLOT_INDEX_W-1:0]     slot_index;
   logic                                  last;
   logic                                  key_too_long;

   modport source (output valid, output port_word, output slot_index, output last,
                   output key_too_long, input ready);
   modport sink   (input valid, input port_word, input slot_index, input last,
                   input key_too_long, output ready);
endinterface

/* src/cbdp_csr.sv */
module cbdp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cbdp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cbdp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cbdp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output cbdp_pkg::cfg_type                   cfg
);

   cbdp_pkg::cfg_type       cfg_ff;
   cbdp_pkg::cfg_type       cfg_in;
   cbdp_pkg::reg_index_type reg_idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = cbdp_pkg::reg_index_type'(
                          csr_paddr[cbdp_pkg::CSR_ADDR_W-1:cbdp_pkg::CSR_LSB]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            cbdp_pkg::REG_KEY_BITS:       cfg_in.key_bits = csr_pwdata;
            cbdp_pkg::REG_KEY_LENGTH:
               cfg_in.key_length = csr_pwdata[cbdp_pkg::KEY_LEN_W-1:0];
            cbdp_pkg::REG_HIGH_MASK:
               cfg_in.high_mask = csr_pwdata[cbdp_pkg::WORD_W-1:0];
            cbdp_pkg::REG_LOW_MASK:
               cfg_in.low_mask = csr_pwdata[cbdp_pkg::WORD_W-1:0];
            cbdp_pkg::REG_CLAMP_MASK:
               cfg_in.clamp_mask = csr_pwdata[cbdp_pkg::WORD_W-1:0];
            cbdp_pkg::REG_OWN_CLAMP_MASK:
               cfg_in.own_clamp_mask = csr_pwdata[cbdp_pkg::WORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cbdp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         cbdp_pkg::REG_KEY_BITS:       csr_prdata = cfg_ff.key_bits;
         cbdp_pkg::REG_KEY_LENGTH:     csr_prdata = cbdp_pkg::CSR_DATA_W'(cfg_ff.key_length);
         cbdp_pkg::REG_HIGH_MASK:      csr_prdata = cbdp_pkg::CSR_DATA_W'(cfg_ff.high_mask);
         cbdp_pkg::REG_LOW_MASK:       csr_prdata = cbdp_pkg::CSR_DATA_W'(cfg_ff.low_mask);
         cbdp_pkg::REG_CLAMP_MASK:     csr_prdata = cbdp_pkg::CSR_DATA_W'(cfg_ff.clamp_mask);
         cbdp_pkg::REG_OWN_CLAMP_MASK:
            csr_prdata = cbdp_pkg::CSR_DATA_W'(cfg_ff.own_clamp_mask);
         default:                      csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* src/coded_burst_drive_pattern.sv */
// Coded burst drive pattern generator.
// Each request on req_chan carries one bit, restart: 1 emits slot 0 of the
// burst buffer, 0 emits the slot after the previous one (wrapping after the
// last slot). Each request yields exactly one response on rsp_chan with the
// port drive word, the slot index, a last-slot flag and the key-too-long flag.
// Burst code and masks are set through the APB-style csr_ port (64-bit data,
// registers at 8-byte spacing); write them only while no request is in flight.
// Responses are registered. Throughput: one request per cycle while
// req_chan.ready is high; slot/period/offset/phase are tracked by counters
// so the drive word comes from one compare and mask selection.
// A two-entry response queue sits between the sides: requests keep flowing
// while one response waits, and req_chan.ready drops only when both entries
// are full, so a stalled receiver loses nothing.
// Reset (synchronous, active high) empties the queue, returns the slot
// counter to 0 and loads register defaults (key length 1, all else 0).
module coded_burst_drive_pattern (
   input  logic                                clock,
   input  logic                                reset,
   cbdp_req_if.sink                            req_chan,
   cbdp_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cbdp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cbdp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cbdp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   cbdp_pkg::cfg_type cfg;

   cbdp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Position of the slot that the next advance emits
   logic [cbdp_pkg::SLOT_W-1:0]   slot_ff,   slot_in;
   logic [cbdp_pkg::OFF_W-1:0]    off_ff,    off_in;
   logic [cbdp_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [cbdp_pkg::PHASE_W-1:0]  phase_ff,  phase_in;

   // Position of the slot emitted for this request
   logic [cbdp_pkg::SLOT_W-1:0]   cur_slot;
   logic [cbdp_pkg::OFF_W-1:0]    cur_off;
   logic [cbdp_pkg::PERIOD_W-1:0] cur_period;
   logic [cbdp_pkg::PHASE_W-1:0]  cur_phase;

   logic                              push;
   logic                              pop;
   logic [cbdp_pkg::KEY_LEN_W-1:0]    key_len_sat;
   logic [cbdp_pkg::SPAN_W-1:0]       span;
   logic                              too_long;
   logic                              past_key;
   logic                              key_bit;
   logic                              drive_slot;
   logic                              first_half;
   logic [cbdp_pkg::WORD_W-1:0]       word;
   logic                              is_last;
   cbdp_pkg::rsp_payload_type         result;

   // Response queue: entry 0 is the head
   cbdp_pkg::rsp_payload_type ent0_ff, ent0_in;
   cbdp_pkg::rsp_payload_type ent1_ff, ent1_in;
   logic [1:0]                count_ff, count_in;

   assign push = req_chan.valid && req_chan.ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   // Restart forces slot 0; otherwise use the tracked position
   always_comb begin
      if (req_chan.restart) begin
         cur_slot   = '0;
         cur_off    = '0;
         cur_period = '0;
         cur_phase  = '0;
      end else begin
         cur_slot   = slot_ff;
         cur_off    = off_ff;
         cur_period = period_ff;
         cur_phase  = phase_ff;
      end
   end

   assign is_last = (cur_slot == cbdp_pkg::SLOT_W'(cbdp_pkg::BUFFER_LENGTH - 1));

   // Advance the position counters; the whole set drops to zero at buffer wrap
   always_comb begin
      slot_in   = slot_ff;
      off_in    = off_ff;
      period_in = period_ff;
      phase_in  = phase_ff;
      if (push) begin
         if (is_last) begin
            slot_in   = '0;
            off_in    = '0;
            period_in = '0;
            phase_in  = '0;
         end else begin
            slot_in = cur_slot + 1'b1;
            if (cur_off == cbdp_pkg::OFF_W'(cbdp_pkg::SLOTS_PER_PERIOD - 1)) begin
               off_in    = '0;
               period_in = cur_period + 1'b1;
            end else begin
               off_in    = cur_off + 1'b1;
               period_in = cur_period;
            end
            if (cur_phase == cbdp_pkg::PHASE_W'(cbdp_pkg::POWER_MODULO - 1)) begin
               phase_in = '0;
            end else begin
               phase_in = cur_phase + 1'b1;
            end
         end
      end
   end

   // Saturate the key length and size the burst span
   assign key_len_sat = (cfg.key_length > cbdp_pkg::KEY_LEN_W'(cbdp_pkg::MAX_KEY_BITS))
                        ? cbdp_pkg::KEY_LEN_W'(cbdp_pkg::MAX_KEY_BITS) : cfg.key_length;
   assign span        = cbdp_pkg::SPAN_W'(key_len_sat * cbdp_pkg::SLOTS_PER_PERIOD);
   assign too_long    = cbdp_pkg::CMP_W'(span) >= cbdp_pkg::CMP_W'(cbdp_pkg::BUFFER_LENGTH);
   assign past_key    = cbdp_pkg::CMP_W'(cur_slot) >= cbdp_pkg::CMP_W'(span);
   assign key_bit     = cfg.key_bits[cbdp_pkg::KEY_IDX_W'(cur_period)];
   assign first_half  = cur_off < cbdp_pkg::OFF_W'(cbdp_pkg::HALF_PERIOD);

   // Skip the first slot of each half and slots off the power phase
   assign drive_slot = (cur_off != '0)
                    && (cur_off != cbdp_pkg::OFF_W'(cbdp_pkg::HALF_PERIOD))
                    && (cur_phase == cbdp_pkg::PHASE_W'(1));

   always_comb begin
      word = cfg.clamp_mask;
      if (!too_long) begin
         if (past_key) begin
            word = cfg.clamp_mask & ~cfg.own_clamp_mask;
         end else if (drive_slot) begin
            // First half uses low side on a one bit, second half the opposite
            if (first_half ^ key_bit) begin
               word = cfg.clamp_mask | cfg.high_mask;
            end else begin
               word = cfg.clamp_mask | cfg.low_mask;
            end
         end
      end
   end

   assign result.port_word    = word;
   assign result.slot_index   = cbdp_pkg::SLOT_INDEX_W'(cur_slot);
   assign result.last         = is_last;
   assign result.key_too_long = too_long;

   // Queue update: pop shifts entry 1 down, push fills the first free entry
   always_comb begin
      ent0_in  = ent0_ff;
      ent1_in  = ent1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b11: begin
            if (count_ff == 2'd2) begin
               ent0_in = ent1_ff;
               ent1_in = result;
            end else begin
               ent0_in = result;
            end
         end
         2'b01: begin
            ent0_in  = ent1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               ent0_in = result;
            end else begin
               ent1_in = result;
            end
            count_in = count_ff + 2'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         off_ff    <= '0;
         period_ff <= '0;
         phase_ff  <= '0;
         count_ff  <= '0;
      end else begin
         slot_ff   <= slot_in;
         off_ff    <= off_in;
         period_ff <= period_in;
         phase_ff  <= phase_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

   assign req_chan.ready        = (count_ff != 2'd2);
   assign rsp_chan.valid        = (count_ff != 2'd0);
   assign rsp_chan.port_word    = ent0_ff.port_word;
   assign rsp_chan.slot_index   = ent0_ff.slot_index;
   assign rsp_chan.last         = ent0_ff.last;
   assign rsp_chan.key_too_long = ent0_ff.key_too_long;

endmodule
